[rtl/windowed_speed_history_stats_core_defines.svh]
// Assertion macros used by the checker file of the speed history block.
// No dependencies; include this header by its bare file name.
`ifndef WINDOWED_SPEED_HISTORY_STATS_CORE_DEFINES_SVH
`define WINDOWED_SPEED_HISTORY_STATS_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSHS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("speed history check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WSHS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("speed history check failed");

`endif

[rtl/wshs_pkg.sv]
// Types, codes and helper functions of the windowed speed history block.
// No dependencies.
package wshs_pkg;

  // Operation codes carried in the request word.
  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_AVG   = 3'd1,
    OP_GUST  = 3'd2,
    OP_COUNT = 3'd3,
    OP_SIZE  = 3'd4
  } op_e;

  // Status codes of the response word.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_DATA = 2'd1,
    ST_TOO_OLD = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // Sequencer states, one-hot.
  typedef enum logic [10:0] {
    S_IDLE      = 11'b00000000001,
    S_PRUNE_RD  = 11'b00000000010,
    S_PRUNE_CHK = 11'b00000000100,
    S_DISPATCH  = 11'b00000001000,
    S_INS_RD    = 11'b00000010000,
    S_INS_CHK   = 11'b00000100000,
    S_SCAN_RD   = 11'b00001000000,
    S_SCAN_CHK  = 11'b00010000000,
    S_FINISH    = 11'b00100000000,
    S_DIV       = 11'b01000000000,
    S_DONE      = 11'b10000000000
  } state_e;

  // One stored sample.
  typedef struct packed {
    logic [31:0] stamp;
    logic [15:0] speed;
  } entry_t;

  localparam logic [31:0] MaxAgeReset = 32'd600;

  // True when the stamp is not older than limit seconds at time now.
  function automatic logic is_fresh(input logic [31:0] now, input logic [31:0] stamp,
                                    input logic [31:0] limit);
    return (stamp >= now) || ((now - stamp) <= limit);
  endfunction

endpackage

[rtl/wshs_if.sv]
// Valid/ready channel interfaces for the request and response words.
// Uses no package.
interface wshs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [31:0] present_time;
  logic [31:0] sample_time;
  logic [15:0] sample_speed;
  logic [31:0] window_span;

  modport source (output valid, opcode, present_time, sample_time, sample_speed,
                  window_span, input ready);
  modport sink (input valid, opcode, present_time, sample_time, sample_speed,
                window_span, output ready);
endinterface

interface wshs_out_if #(parameter int CNT_W = 7);
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [15:0]      speed_result;
  logic [31:0]      gust_time;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, status, speed_result, gust_time, entry_count,
                  input ready);
  modport sink (input valid, status, speed_result, gust_time, entry_count,
                output ready);
endinterface

[rtl/windowed_speed_history_stats_core.sv]
// Windowed speed history: a sorted circular store of timestamped speeds with
// window statistics. Depends on wshs_pkg and the interfaces in wshs_if.sv.
//
// The block takes one request word at a time and is not ready while it works.
// Every word first drops stale samples from the oldest end (a read state and
// a check state per dropped sample), then runs its operation on a sample
// memory with one read and one write port: an add moves newer samples up one
// slot, and average, gust and span count walk back from the newest sample
// until one falls outside the span. An average then runs a restoring divider,
// one quotient bit per cycle. The result sits in an output register, so the
// next word is taken while it waits.
// The sample memory needs no clearing after reset.
module windowed_speed_history_stats_core #(
  parameter int DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  wshs_in_if.sink           req_i,
  wshs_out_if.source        rsp_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int TW = 16 + CW;
  localparam int IW = $clog2(TW);

  // Sequencer and latched request.
  wshs_pkg::state_e state_q;
  logic [2:0]       op_q;
  logic [31:0]      now_q;
  logic [31:0]      st_q;
  logic [15:0]      sp_q;
  logic [31:0]      span_q;

  logic [31:0]      max_age_q;
  logic [AW-1:0]    oldest_q;
  logic [CW-1:0]    count_q;
  logic [CW-1:0]    k_q;
  logic [CW-1:0]    n_q;
  logic [TW-1:0]    total_q;
  wshs_pkg::entry_t best_q;

  // Divider registers.
  logic [CW-1:0]    rem_q;
  logic [TW-1:0]    dvd_q;
  logic [IW-1:0]    iter_q;

  // Result being built and result on offer.
  logic [1:0]       res_status_q;
  logic [15:0]      res_speed_q;
  logic [31:0]      res_gtime_q;
  logic [CW-1:0]    res_cnt_q;
  logic             out_valid_q;
  logic [1:0]       out_status_q;
  logic [15:0]      out_speed_q;
  logic [31:0]      out_gtime_q;
  logic [CW-1:0]    out_cnt_q;

  // Sample memory.
  wshs_pkg::entry_t mem_q [DEPTH];
  wshs_pkg::entry_t rd_q;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr;
  wshs_pkg::entry_t mem_wdata;
  wshs_pkg::entry_t new_entry;

  logic [AW-1:0]    slot_k;
  logic [AW-1:0]    slot_km1;
  logic [AW-1:0]    oldest_inc;
  logic             rd_fresh;
  logic             rd_in_span;
  logic [SW-1:0]    div_shift;
  logic             div_bit;
  logic [SW-1:0]    div_sub;

  // Circular slot of a logical position.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                           input logic [CW-1:0] pos);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(pos);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign slot_k     = slot_of(oldest_q, k_q);
  assign slot_km1   = slot_of(oldest_q, k_q - CW'(1));
  assign oldest_inc = (oldest_q == AW'(DEPTH - 1)) ? '0 : oldest_q + AW'(1);
  assign rd_fresh   = wshs_pkg::is_fresh(now_q, rd_q.stamp, max_age_q);
  assign rd_in_span = wshs_pkg::is_fresh(now_q, rd_q.stamp, span_q);
  assign new_entry  = '{stamp: st_q, speed: sp_q};

  // One restoring division step.
  assign div_shift = {rem_q, dvd_q[TW-1]};
  assign div_bit   = div_shift >= SW'(n_q);
  assign div_sub   = div_shift - SW'(n_q);

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_k;
    mem_wdata = new_entry;
    mem_raddr = oldest_q;
    case (state_q)
      wshs_pkg::S_PRUNE_RD: begin
        mem_raddr = oldest_q;
      end
      wshs_pkg::S_INS_RD: begin
        mem_raddr = slot_km1;
        mem_we    = (k_q == '0);
      end
      wshs_pkg::S_INS_CHK: begin
        mem_we    = 1'b1;
        mem_wdata = (rd_q.stamp > st_q) ? rd_q : new_entry;
      end
      wshs_pkg::S_SCAN_RD: begin
        mem_raddr = slot_km1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_raddr];
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q <= wshs_pkg::MaxAgeReset;
    end else if (cfg_we_i) begin
      max_age_q <= cfg_wdata_i;
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wshs_pkg::S_IDLE;
      oldest_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // The done state loads the output register itself.
      if (out_valid_q && rsp_o.ready && (state_q != wshs_pkg::S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        wshs_pkg::S_IDLE: begin
          if (req_i.valid) begin
            op_q         <= req_i.opcode;
            now_q        <= req_i.present_time;
            st_q         <= req_i.sample_time;
            sp_q         <= req_i.sample_speed;
            span_q       <= req_i.window_span;
            res_status_q <= wshs_pkg::ST_OK;
            res_speed_q  <= '0;
            res_gtime_q  <= '0;
            res_cnt_q    <= '0;
            state_q      <= wshs_pkg::S_PRUNE_RD;
          end
        end
        wshs_pkg::S_PRUNE_RD: begin
          state_q <= (count_q == '0) ? wshs_pkg::S_DISPATCH : wshs_pkg::S_PRUNE_CHK;
        end
        wshs_pkg::S_PRUNE_CHK: begin
          if (!rd_fresh) begin
            oldest_q <= oldest_inc;
            count_q  <= count_q - CW'(1);
            state_q  <= wshs_pkg::S_PRUNE_RD;
          end else begin
            state_q <= wshs_pkg::S_DISPATCH;
          end
        end
        wshs_pkg::S_DISPATCH: begin
          k_q     <= count_q;
          n_q     <= '0;
          total_q <= '0;
          case (op_q)
            wshs_pkg::OP_ADD: begin
              if (!wshs_pkg::is_fresh(now_q, st_q, max_age_q)) begin
                res_status_q <= wshs_pkg::ST_TOO_OLD;
                state_q      <= wshs_pkg::S_DONE;
              end else if (count_q == CW'(DEPTH)) begin
                res_status_q <= wshs_pkg::ST_FULL;
                state_q      <= wshs_pkg::S_DONE;
              end else begin
                state_q <= wshs_pkg::S_INS_RD;
              end
            end
            wshs_pkg::OP_AVG, wshs_pkg::OP_COUNT: begin
              state_q <= wshs_pkg::S_SCAN_RD;
            end
            wshs_pkg::OP_GUST: begin
              if (count_q == '0) begin
                res_status_q <= wshs_pkg::ST_NO_DATA;
                state_q      <= wshs_pkg::S_DONE;
              end else begin
                state_q <= wshs_pkg::S_SCAN_RD;
              end
            end
            wshs_pkg::OP_SIZE: begin
              res_cnt_q <= count_q;
              state_q   <= wshs_pkg::S_DONE;
            end
            default: begin
              state_q <= wshs_pkg::S_DONE;
            end
          endcase
        end
        // Ordered insert: shift newer samples up until the slot is found.
        wshs_pkg::S_INS_RD: begin
          if (k_q == '0) begin
            count_q <= count_q + CW'(1);
            state_q <= wshs_pkg::S_DONE;
          end else begin
            state_q <= wshs_pkg::S_INS_CHK;
          end
        end
        wshs_pkg::S_INS_CHK: begin
          if (rd_q.stamp > st_q) begin
            k_q     <= k_q - CW'(1);
            state_q <= wshs_pkg::S_INS_RD;
          end else begin
            count_q <= count_q + CW'(1);
            state_q <= wshs_pkg::S_DONE;
          end
        end
        // Walk back from the newest sample while it lies in the span.
        wshs_pkg::S_SCAN_RD: begin
          state_q <= (k_q == '0) ? wshs_pkg::S_FINISH : wshs_pkg::S_SCAN_CHK;
        end
        wshs_pkg::S_SCAN_CHK: begin
          if ((k_q == count_q) || (rd_in_span && (rd_q.speed > best_q.speed))) begin
            best_q <= rd_q;
          end
          if (rd_in_span) begin
            total_q <= total_q + TW'(rd_q.speed);
            n_q     <= n_q + CW'(1);
            k_q     <= k_q - CW'(1);
            state_q <= wshs_pkg::S_SCAN_RD;
          end else begin
            state_q <= wshs_pkg::S_FINISH;
          end
        end
        wshs_pkg::S_FINISH: begin
          case (op_q)
            wshs_pkg::OP_AVG: begin
              if (n_q == '0) begin
                res_status_q <= wshs_pkg::ST_NO_DATA;
                state_q      <= wshs_pkg::S_DONE;
              end else begin
                dvd_q   <= total_q;
                rem_q   <= '0;
                iter_q  <= '0;
                state_q <= wshs_pkg::S_DIV;
              end
            end
            wshs_pkg::OP_GUST: begin
              res_speed_q <= best_q.speed;
              res_gtime_q <= best_q.stamp;
              state_q     <= wshs_pkg::S_DONE;
            end
            wshs_pkg::OP_COUNT: begin
              res_cnt_q <= n_q;
              state_q   <= wshs_pkg::S_DONE;
            end
            default: begin
              res_cnt_q <= '0;
              state_q   <= wshs_pkg::S_DONE;
            end
          endcase
        end
        // Restoring divide, one quotient bit per cycle.
        wshs_pkg::S_DIV: begin
          rem_q  <= div_bit ? div_sub[CW-1:0] : div_shift[CW-1:0];
          dvd_q  <= {dvd_q[TW-2:0], div_bit};
          iter_q <= iter_q + IW'(1);
          if (iter_q == IW'(TW - 1)) begin
            res_speed_q <= {dvd_q[14:0], div_bit};
            state_q     <= wshs_pkg::S_DONE;
          end
        end
        // Hand the word to the output register once it is free.
        wshs_pkg::S_DONE: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_speed_q  <= res_speed_q;
            out_gtime_q  <= res_gtime_q;
            out_cnt_q    <= res_cnt_q;
            state_q      <= wshs_pkg::S_IDLE;
          end
        end
        default: begin
          state_q <= wshs_pkg::S_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready        = (state_q == wshs_pkg::S_IDLE);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.speed_result = out_speed_q;
  assign rsp_o.gust_time    = out_gtime_q;
  assign rsp_o.entry_count  = out_cnt_q;

endmodule

[rtl/wshs_checker.sv]
// Port-level checks of the speed history block, bound to its top level.
// Depends on wshs_pkg and windowed_speed_history_stats_core_defines.svh.
`include "windowed_speed_history_stats_core_defines.svh"

module wshs_checker #(
  parameter int DEPTH = 64,
  parameter int CW    = 7
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input logic [1:0]    status_i,
  input logic [15:0]   speed_result_i,
  input logic [31:0]   gust_time_i,
  input logic [CW-1:0] entry_count_i
);

  // A waiting response word holds until it is taken.
  `WSHS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(status_i) && $stable(speed_result_i) && $stable(gust_time_i) && $stable(entry_count_i))

  // The block works on one word at a time.
  `WSHS_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // No count can exceed the store depth.
  `WSHS_ASSERT_IMP(a_count_bound, clk_i, rst_ni, out_valid_i, entry_count_i <= CW'(DEPTH))

  // A refused add reports nothing besides its status.
  `WSHS_ASSERT_IMP(a_refused_clean, clk_i, rst_ni, out_valid_i && (status_i == wshs_pkg::ST_TOO_OLD || status_i == wshs_pkg::ST_FULL), speed_result_i == '0 && gust_time_i == '0 && entry_count_i == '0)

endmodule

bind windowed_speed_history_stats_core wshs_checker #(
  .DEPTH(DEPTH),
  .CW   (CW)
) u_wshs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .speed_result_i(rsp_o.speed_result),
  .gust_time_i   (rsp_o.gust_time),
  .entry_count_i (rsp_o.entry_count)
);

[tb/windowed_speed_history_stats_core_tb.sv]
// Self-checking testbench for the windowed speed history block: directed table, then random words.
// Depends on wshs_pkg, the channel interfaces in wshs_if.sv and the core module.
module windowed_speed_history_stats_core_tb;

  localparam int          Slots      = 64;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned AnsDepth   = 4096;

  // One response word, packed for comparison.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] speed;
    logic [31:0] gtime;
    logic [6:0]  cnt;
  } answer_t;

  // One row of the directed table; known marks an answer typed in by hand.
  typedef struct {
    logic [2:0]  op;
    logic [31:0] now;
    logic [31:0] stamp;
    logic [15:0] speed;
    logic [31:0] span;
    bit          known;
    answer_t     ans;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [31:0] cfg_wdata_i;

  wshs_in_if req_if ();
  wshs_out_if #(.CNT_W(7)) rsp_if ();

  windowed_speed_history_stats_core #(.DEPTH(Slots)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Mirror of the sample history used for prediction.
  logic [31:0] hist_stamp [Slots];
  logic [15:0] hist_speed [Slots];
  int unsigned head_slot;
  int unsigned held;
  logic [31:0] age_limit;

  // Expected answers in order, written by the sender and read by the checker.
  answer_t     ans_fifo [AnsDepth];
  int unsigned ans_wr;
  int unsigned ans_rd;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned words_taken;
  int unsigned send_gap_max;
  int unsigned recv_gap_max;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // A stamp counts as fresh when it is not older than limit, or in the future.
  function automatic bit in_window(logic [31:0] now, logic [31:0] stamp, logic [31:0] limit);
    return (stamp >= now) || ((now - stamp) <= limit);
  endfunction

  function automatic int unsigned ring_pos(int unsigned k);
    return (head_slot + k) % Slots;
  endfunction

  // Applies one request word to the mirror and returns the answer it produces.
  function automatic answer_t apply_word(logic [2:0] op, logic [31:0] now, logic [31:0] stamp,
                                         logic [15:0] speed, logic [31:0] span);
    answer_t     r;
    int unsigned k;
    int unsigned best;
    int unsigned n;
    logic [31:0] total;
    r = '0;
    while (held > 0 && !in_window(now, hist_stamp[ring_pos(0)], age_limit)) begin
      head_slot = (head_slot + 1) % Slots;
      held--;
    end
    if (op == wshs_pkg::OP_ADD) begin
      if (!in_window(now, stamp, age_limit)) begin
        r.status = wshs_pkg::ST_TOO_OLD;
      end else if (held >= Slots) begin
        r.status = wshs_pkg::ST_FULL;
      end else begin
        k = held;
        while (k > 0 && hist_stamp[ring_pos(k - 1)] > stamp) begin
          hist_stamp[ring_pos(k)] = hist_stamp[ring_pos(k - 1)];
          hist_speed[ring_pos(k)] = hist_speed[ring_pos(k - 1)];
          k--;
        end
        hist_stamp[ring_pos(k)] = stamp;
        hist_speed[ring_pos(k)] = speed;
        held++;
      end
    end else if (op == wshs_pkg::OP_AVG) begin
      total = '0;
      n = 0;
      k = held;
      while (k > 0 && in_window(now, hist_stamp[ring_pos(k - 1)], span)) begin
        total += hist_speed[ring_pos(k - 1)];
        n++;
        k--;
      end
      if (n == 0) r.status = wshs_pkg::ST_NO_DATA;
      else r.speed = 16'(total / n);
    end else if (op == wshs_pkg::OP_GUST) begin
      if (held == 0) begin
        r.status = wshs_pkg::ST_NO_DATA;
      end else begin
        best = ring_pos(held - 1);
        k = held;
        while (k > 0 && in_window(now, hist_stamp[ring_pos(k - 1)], span)) begin
          if (hist_speed[ring_pos(k - 1)] > hist_speed[best]) best = ring_pos(k - 1);
          k--;
        end
        r.speed = hist_speed[best];
        r.gtime = hist_stamp[best];
      end
    end else if (op == wshs_pkg::OP_COUNT) begin
      for (k = 0; k < held; k++)
        if (in_window(now, hist_stamp[ring_pos(k)], span)) r.cnt++;
    end else if (op == wshs_pkg::OP_SIZE) begin
      r.cnt = 7'(held);
    end
    return r;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0h, want %0h (word %0d)", field, got, want, words_taken);
    mismatches++;
  endtask

  // Offers one word, waits for acceptance, records the answer, then may idle for a random gap.
  task automatic send_word(logic [2:0] op, logic [31:0] now, logic [31:0] stamp,
                           logic [15:0] speed, logic [31:0] span, bit known, answer_t ans);
    answer_t     predicted;
    int unsigned gap;
    req_if.valid        <= 1'b1;
    req_if.opcode       <= op;
    req_if.present_time <= now;
    req_if.sample_time  <= stamp;
    req_if.sample_speed <= speed;
    req_if.window_span  <= span;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predicted = apply_word(op, now, stamp, speed, span);
    ans_fifo[ans_wr % AnsDepth] = known ? ans : predicted;
    ans_wr++;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops offering and waits until every expected answer has come back.
  task automatic drain_answers();
    req_if.valid <= 1'b0;
    while (ans_wr != ans_rd) @(posedge clk_i);
  endtask

  // Waits for every answer, then lets the block settle before a register write.
  task automatic write_max_age(logic [31:0] value);
    drain_answers();
    repeat (20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    age_limit = value;
  endtask

  // Random words: mostly a coherent timeline with fresh and stale samples, some noise.
  task automatic random_phase(int unsigned words, int unsigned add_pct);
    logic [31:0] tnow;
    logic [31:0] reach;
    logic [31:0] stamp;
    logic [2:0]  op;
    int unsigned i;
    tnow = $urandom();
    reach = (age_limit > 200) ? 32'd200 : age_limit + age_limit / 4 + 2;
    for (i = 0; i < words; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(3'($urandom_range(0, 7)), $urandom(), $urandom(), 16'($urandom()),
                  $urandom(), 1'b0, '0);
      end else begin
        tnow += ($urandom_range(0, 19) == 0) ? $urandom_range(0, 3 * reach) :
                                               $urandom_range(0, 2);
        if ($urandom_range(0, 99) < add_pct) op = wshs_pkg::OP_ADD;
        else op = 3'($urandom_range(wshs_pkg::OP_AVG, wshs_pkg::OP_SIZE));
        if ($urandom_range(0, 15) == 0) stamp = tnow + $urandom_range(0, 5);
        else stamp = tnow - $urandom_range(0, reach);
        send_word(op, tnow, stamp, 16'($urandom()), $urandom_range(0, reach), 1'b0, '0);
      end
    end
  endtask

  // Directed rows; typed answers cover reset state, empty store, too old, an add, unused codes.
  row_t rows [] = '{
    '{wshs_pkg::OP_SIZE, 32'd1000, 32'd0, 16'd0, 32'd0, 1'b1,
      '{wshs_pkg::ST_OK, 16'd0, 32'd0, 7'd0}},
    '{wshs_pkg::OP_AVG, 32'd1000, 32'd0, 16'd0, 32'hFFFFFFFF, 1'b1,
      '{wshs_pkg::ST_NO_DATA, 16'd0, 32'd0, 7'd0}},
    '{wshs_pkg::OP_GUST, 32'd1000, 32'd0, 16'd0, 32'hFFFFFFFF, 1'b1,
      '{wshs_pkg::ST_NO_DATA, 16'd0, 32'd0, 7'd0}},
    '{wshs_pkg::OP_ADD, 32'd1000, 32'd399, 16'd5, 32'd0, 1'b1,
      '{wshs_pkg::ST_TOO_OLD, 16'd0, 32'd0, 7'd0}},
    '{wshs_pkg::OP_ADD, 32'd1000, 32'd400, 16'hFFFF, 32'd0, 1'b1,
      '{wshs_pkg::ST_OK, 16'd0, 32'd0, 7'd0}},
    '{wshs_pkg::OP_ADD, 32'd1000, 32'd1000, 16'd0, 32'd0, 1'b0, '0},
    '{wshs_pkg::OP_ADD, 32'd1000, 32'd400, 16'd10, 32'd0, 1'b0, '0},
    '{wshs_pkg::OP_ADD, 32'd1000, 32'hFFFFFFFF, 16'd7, 32'd0, 1'b0, '0},
    '{wshs_pkg::OP_ADD, 32'd1000, 32'd1000, 16'hFFFF, 32'd0, 1'b0, '0},
    '{wshs_pkg::OP_AVG, 32'd1000, 32'd0, 16'd0, 32'd0, 1'b0, '0},
    '{wshs_pkg::OP_AVG, 32'd1000, 32'd0, 16'd0, 32'hFFFFFFFF, 1'b0, '0},
    '{wshs_pkg::OP_GUST, 32'd1000, 32'd0, 16'd0, 32'd0, 1'b0, '0},
    '{wshs_pkg::OP_GUST, 32'd1000, 32'd0, 16'd0, 32'hFFFFFFFF, 1'b0, '0},
    '{wshs_pkg::OP_COUNT, 32'd1000, 32'd0, 16'd0, 32'd0, 1'b0, '0},
    '{wshs_pkg::OP_COUNT, 32'd1000, 32'd0, 16'd0, 32'hFFFFFFFF, 1'b0, '0},
    '{3'd5, 32'd1000, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 1'b1, '0},
    '{3'd6, 32'd1000, 32'd0, 16'd0, 32'd0, 1'b1, '0},
    '{3'd7, 32'd1000, 32'd0, 16'd0, 32'd0, 1'b1, '0},
    '{wshs_pkg::OP_ADD, 32'd2000, 32'd1500, 16'd33, 32'd0, 1'b0, '0},
    '{wshs_pkg::OP_GUST, 32'd2000, 32'd0, 16'd0, 32'd10, 1'b0, '0},
    '{wshs_pkg::OP_SIZE, 32'hFFFFFFFF, 32'd0, 16'd0, 32'd0, 1'b0, '0},
    '{wshs_pkg::OP_COUNT, 32'hFFFFFFFF, 32'd0, 16'd0, 32'd0, 1'b0, '0}
  };

  // Stimulus: directed table, then random phases across several max_age settings.
  initial begin
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_wdata_i         <= '0;
    req_if.valid        <= 1'b0;
    req_if.opcode       <= '0;
    req_if.present_time <= '0;
    req_if.sample_time  <= '0;
    req_if.sample_speed <= '0;
    req_if.window_span  <= '0;
    head_slot = 0;
    held = 0;
    age_limit = wshs_pkg::MaxAgeReset;
    send_gap_max = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i])
      send_word(rows[i].op, rows[i].now, rows[i].stamp, rows[i].speed, rows[i].span,
                rows[i].known, rows[i].ans);

    send_gap_max = 14;
    random_phase(250, 45);
    // Sender holds back until the block has answered everything.
    drain_answers();
    send_gap_max = 0;
    random_phase(100, 45);
    write_max_age(32'd0);
    send_gap_max = 14;
    random_phase(150, 50);
    // A huge age keeps every sample, so a burst of adds fills the store.
    write_max_age(32'hFFFFFFFF);
    send_gap_max = 0;
    random_phase(120, 90);
    send_gap_max = 14;
    random_phase(150, 40);
    write_max_age(32'd30);
    random_phase(200, 50);
    write_max_age($urandom_range(1000, 100000));
    send_gap_max = 0;
    random_phase(200, 55);

    drain_answers();
    repeat (300) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: random stalls, stretches of full speed, and one long hold-off.
  initial begin
    int unsigned gap;
    int unsigned got;
    got = 0;
    recv_gap_max = 14;
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (got % 150 == 0) recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
      gap = (got == 400) ? 600 : $urandom_range(0, recv_gap_max);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
      got++;
    end
  end

  // Checks each delivered word against the oldest pending answer.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      words_taken++;
      if (ans_wr == ans_rd) begin
        $display("unexpected word %0d with no answer pending", words_taken);
        mismatches++;
      end else begin
        want = ans_fifo[ans_rd % AnsDepth];
        ans_rd++;
        if (rsp_if.status !== want.status) report("status", rsp_if.status, want.status);
        if (rsp_if.speed_result !== want.speed) report("speed", rsp_if.speed_result, want.speed);
        if (rsp_if.gust_time !== want.gtime) report("gust time", rsp_if.gust_time, want.gtime);
        if (rsp_if.entry_count !== want.cnt) report("count", rsp_if.entry_count, want.cnt);
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    cycles = 0;
    words_taken = 0;
    ans_wr = 0;
    ans_rd = 0;
  end

endmodule
